>>> hdl/prpi_pkg.sv
// Shared types and constants for the PageRank power-iteration block.
package prpi_pkg;

  // Page count and derived index widths
  localparam int unsigned PAGES  = 4;
  localparam int unsigned IDX_W  = $clog2(PAGES);
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned CELLS  = PAGES * PAGES;

  // Field widths
  localparam int unsigned VAL_W  = 32;  // Q1.31
  localparam int unsigned ACC_W  = 63;  // Q1.62, holds up to 1.0
  localparam int unsigned PROD_W = 64;  // full product / squared distance
  localparam int unsigned TOL_W  = 63;
  localparam int unsigned PASS_W = 16;
  localparam int unsigned CFG_W  = 63;

  // Fixed-point constants
  localparam logic [VAL_W-1:0] ONE_Q31   = VAL_W'(64'd1 << 31);
  localparam logic [ACC_W-1:0] ONE_Q62   = ACC_W'(64'd1 << 62);
  localparam logic [ACC_W-1:0] HALF_Q31  = ACC_W'(64'd1 << 30);
  localparam logic [VAL_W-1:0] RANK_INIT = VAL_W'((64'd1 << 31) / PAGES);

  // Configuration register reset values
  localparam logic [TOL_W-1:0]  TOL_RST  = '0;
  localparam logic [PASS_W-1:0] PASS_RST = PASS_W'(1000);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TOLERANCE  = 1'b0,
    REG_MAX_PASSES = 1'b1
  } reg_idx_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_DSQ,
    ST_DACC,
    ST_CHECK,
    ST_COPY,
    ST_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic             init;      // load uniform ranks, clear pass count
    logic             mul_rank;  // product of matrix entry and rank
    logic             mul_dist;  // square of rank difference
    logic             acc_add;   // add product into row sum
    logic             round;     // round row sum into next rank
    logic             dist_add;  // add square into distance sum
    logic             check;     // latch convergence flag
    logic             copy;      // next ranks become previous ranks
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] out_idx;
  } prpi_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic met;      // distance at or below tolerance
    logic cap_hit;  // pass count reached the cap
  } prpi_sts_t;

endpackage

>>> hdl/prpi_dpath.sv
// Datapath: link matrix, rank vectors, shared multiplier, sums and config.
module prpi_dpath import prpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prpi_cmd_t         cmd_i,
  input  logic              load_i,
  input  logic [IDX_W-1:0]  load_row_i,
  input  logic [IDX_W-1:0]  load_col_i,
  input  logic [VAL_W-1:0]  load_value_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output prpi_sts_t         sts_o,
  output logic [VAL_W-1:0]  rank_o,
  output logic              conv_o,
  output logic [PASS_W-1:0] pass_o
);

  logic [VAL_W-1:0]  mat_q  [CELLS];
  logic [VAL_W-1:0]  prev_q [PAGES];
  logic [VAL_W-1:0]  next_q [PAGES];
  logic [PROD_W-1:0] mul_q;
  logic [ACC_W-1:0]  acc_q;
  logic [PROD_W-1:0] dist_q;
  logic [TOL_W-1:0]  tol_q;
  logic [PASS_W-1:0] max_q;
  logic [PASS_W-1:0] pass_q;
  logic              conv_q;

  logic [VAL_W-1:0]  load_clamped;
  logic [VAL_W-1:0]  mul_a, mul_b, diff;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]  rnd_sum;
  logic [VAL_W-1:0]  rnd_val;
  logic [PROD_W:0]   dist_sum;
  logic [PROD_W-1:0] dist_d;
  logic [PASS_W-1:0] cap;
  logic              met;

  // Clamp weights above 1.0
  assign load_clamped = (load_value_i > ONE_Q31) ? ONE_Q31 : load_value_i;

  // Operand select for the shared multiplier
  always_comb begin
    diff = (next_q[cmd_i.row] >= prev_q[cmd_i.row]) ?
           (next_q[cmd_i.row] - prev_q[cmd_i.row]) :
           (prev_q[cmd_i.row] - next_q[cmd_i.row]);
    if (cmd_i.mul_dist) begin
      mul_a = diff;
      mul_b = diff;
    end else begin
      mul_a = mat_q[{cmd_i.row, cmd_i.col}];
      mul_b = prev_q[cmd_i.col];
    end
  end

  // Row sum saturates at 1.0
  always_comb begin
    acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(mul_q);
    acc_d   = (acc_sum > (ACC_W + 1)'(ONE_Q62)) ? ONE_Q62 : acc_sum[ACC_W-1:0];
  end

  // Round half up to Q1.31, saturate at 1.0
  always_comb begin
    rnd_sum = acc_q + HALF_Q31;
    rnd_val = (rnd_sum[ACC_W-1:31] > ONE_Q31) ? ONE_Q31 : rnd_sum[ACC_W-1:31];
  end

  // Distance sum saturates at all ones
  always_comb begin
    dist_sum = {1'b0, dist_q} + {1'b0, mul_q};
    dist_d   = dist_sum[PROD_W] ? '1 : dist_sum[PROD_W-1:0];
  end

  // Stop tests
  assign cap = (max_q == '0) ? PASS_W'(1) : max_q;
  assign met = (dist_q <= {1'b0, tol_q});
  assign sts_o.met     = met;
  assign sts_o.cap_hit = (pass_q >= cap);

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mat_q[{load_row_i, load_col_i}] <= load_clamped;
    end
    if (cmd_i.mul_rank || cmd_i.mul_dist) begin
      mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.init || cmd_i.copy || cmd_i.round) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_d;
    end
    if (cmd_i.round) begin
      next_q[cmd_i.row] <= rnd_val;
    end
    if (cmd_i.init || cmd_i.copy) begin
      dist_q <= '0;
    end else if (cmd_i.dist_add) begin
      dist_q <= dist_d;
    end
    for (int k = 0; k < PAGES; k++) begin
      if (cmd_i.init) begin
        prev_q[k] <= RANK_INIT;
      end else if (cmd_i.copy) begin
        prev_q[k] <= next_q[k];
      end
    end
  end

  // Config, pass count and convergence flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RST;
      max_q  <= PASS_RST;
      pass_q <= '0;
      conv_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_TOLERANCE:  tol_q <= cfg_data_i[TOL_W-1:0];
          REG_MAX_PASSES: max_q <= cfg_data_i[PASS_W-1:0];
          default:        ;
        endcase
      end
      if (cmd_i.init) begin
        pass_q <= '0;
      end else if (cmd_i.round && (cmd_i.row == IDX_W'(PAGES - 1))) begin
        pass_q <= pass_q + PASS_W'(1);
      end
      if (cmd_i.check) begin
        conv_q <= met;
      end
    end
  end

  assign rank_o = next_q[cmd_i.out_idx];
  assign conv_o = conv_q;
  assign pass_o = pass_q;

endmodule

>>> hdl/prpi_ctrl.sv
// Controller: load, iteration sequencing and result delivery.
module prpi_ctrl import prpi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      load_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      out_last_o,
  input  prpi_sts_t sts_i,
  output prpi_cmd_t cmd_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] row_q, col_q, out_q;
  logic             row_end, col_end, out_end, in_hs, out_hs;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGES - 1);

  assign row_end = (row_q == LAST_IDX);
  assign col_end = (col_q == LAST_IDX);
  assign out_end = (out_q == LAST_IDX);
  assign in_hs   = in_valid_i && in_ready_o;
  assign out_hs  = out_valid_o && out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_hs && in_last_i) state_d = ST_INIT;
      ST_INIT:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = col_end ? ST_ROUND : ST_MUL;
      ST_ROUND: state_d = row_end ? ST_DSQ : ST_MUL;
      ST_DSQ:   state_d = ST_DACC;
      ST_DACC:  state_d = row_end ? ST_CHECK : ST_DSQ;
      ST_CHECK: state_d = (sts_i.met || sts_i.cap_hit) ? ST_OUT : ST_COPY;
      ST_COPY:  state_d = ST_MUL;
      ST_OUT:   if (out_hs && out_end) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.row     = row_q;
    cmd_o.col     = col_q;
    cmd_o.out_idx = out_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o     = 1'b1;
      ST_INIT:  cmd_o.init     = 1'b1;
      ST_MUL:   cmd_o.mul_rank = 1'b1;
      ST_ACC:   cmd_o.acc_add  = 1'b1;
      ST_ROUND: cmd_o.round    = 1'b1;
      ST_DSQ:   cmd_o.mul_dist = 1'b1;
      ST_DACC:  cmd_o.dist_add = 1'b1;
      ST_CHECK: cmd_o.check    = 1'b1;
      ST_COPY:  cmd_o.copy     = 1'b1;
      ST_OUT:   out_valid_o    = 1'b1;
      default:  ;
    endcase
  end

  assign load_o     = in_hs;
  assign out_last_o = out_end;

  // State and index counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_INIT, ST_COPY: begin
          row_q <= '0;
          col_q <= '0;
          out_q <= '0;
        end
        ST_ACC:   col_q <= col_q + IDX_W'(1);
        ST_ROUND: row_q <= row_q + IDX_W'(1);
        ST_DACC:  row_q <= row_q + IDX_W'(1);
        ST_OUT:   if (out_hs) out_q <= out_q + IDX_W'(1);
        default:  ;
      endcase
    end
  end

endmodule

>>> hdl/pagerank_power_iteration.sv
// Top level of the PageRank power-iteration block over a 4x4 link matrix.
//
//  Channel   Dir  Payload                                    Marker
//  s_axis    in   tdata: entry_row, entry_col, entry_value   tlast: is_last
//  m_axis    out  tdata: rank_index, rank_value, pass_count  tuser: converged, tlast: last_rank
//  cfg       in   index 0: tolerance_squared, 1: max_passes  write enable
//
// Matrix entries load at one transaction per cycle while idle. A transaction with tlast
// starts a run: a setup step, then per pass a multiply and add per matrix entry and a
// rounding per row for the row sums, a square and add per page for the distance, a stop
// test and a ranks copy (not on the final pass), all through one shared 32x32 multiplier.
// Input is held off from the last entry until all PAGES results are taken,
// one per cycle when m_axis_tready stays high.
// Reset is asynchronous, active low; the matrix is not cleared.
module pagerank_power_iteration import prpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,   // entry_row, entry_col, entry_value, pad
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata,   // rank_index, rank_value, pass_count, pad
  output logic [0:0]        m_axis_tuser,   // converged
  output logic              m_axis_tlast,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  prpi_cmd_t         cmd;
  prpi_sts_t         sts;
  logic              load;
  logic [VAL_W-1:0]  rank;
  logic              conv;
  logic [PASS_W-1:0] pass;
  logic [IDX_W-1:0]  out_idx;

  // Sequencer
  prpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .load_o      (load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage
  prpi_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .load_i       (load),
    .load_row_i   (s_axis_tdata[1:0]),
    .load_col_i   (s_axis_tdata[3:2]),
    .load_value_i (s_axis_tdata[35:4]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sts_o        (sts),
    .rank_o       (rank),
    .conv_o       (conv),
    .pass_o       (pass)
  );

  // Result packing
  assign out_idx         = cmd.out_idx;
  assign m_axis_tdata    = {6'd0, pass, rank, out_idx};
  assign m_axis_tuser[0] = conv;

  // Input and output never open at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while results pending");

  // A last entry closes the input until the run is delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after run start");

  // Final result carries the last page index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == IDX_W'(PAGES - 1))
    else $error("last result on wrong page");

  // Every reported run made at least one pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[49:34] != '0)
    else $error("result with zero passes");

endmodule
